// File: sv/ccrs_pkg.sv
// Shared constants and types of the conic column root solver.
package ccrs_pkg;

    localparam int COEF_W   = 16;
    localparam int FRAC     = 8;
    localparam int Y_FRAC   = 16;
    localparam int Y_SHIFT  = (Y_FRAC > FRAC) ? (Y_FRAC - FRAC) : 0;
    localparam int IDX_W    = 3;
    localparam int PROD_W   = 2 * COEF_W;
    localparam int B_W      = PROD_W;
    localparam int C_W      = 3 * COEF_W;
    localparam int DISC_W   = 64;
    localparam int ROOT_W   = DISC_W / 2;
    localparam int REM_W    = ROOT_W + 3;
    localparam int SQ_CELLS = ROOT_W;
    localparam int NUM_W    = B_W + 2 + Y_SHIFT;
    localparam int DEN_W    = COEF_W + 1;
    localparam int DV_CELLS = NUM_W;
    localparam int Y_W      = 32;

    localparam logic [IDX_W-1:0] REG_XX    = 3'd0;
    localparam logic [IDX_W-1:0] REG_XY    = 3'd1;
    localparam logic [IDX_W-1:0] REG_YY    = 3'd2;
    localparam logic [IDX_W-1:0] REG_X     = 3'd3;
    localparam logic [IDX_W-1:0] REG_Y     = 3'd4;
    localparam logic [IDX_W-1:0] REG_CONST = 3'd5;

    typedef struct packed {
        logic signed [COEF_W-1:0] xx;
        logic signed [COEF_W-1:0] xy;
        logic signed [COEF_W-1:0] yy;
        logic signed [COEF_W-1:0] x;
        logic signed [COEF_W-1:0] y;
        logic signed [COEF_W-1:0] cst;
    } t_coefs;

    typedef struct packed {
        logic [DISC_W-1:0]     v;
        logic [REM_W-1:0]      rem;
        logic [ROOT_W-1:0]     root;
        logic signed [B_W-1:0] b;
        logic [COEF_W-1:0]     x;
        logic                  degen;
        logic                  noroot;
    } t_sq;

    typedef struct packed {
        logic [NUM_W-1:0] n1;
        logic [NUM_W-1:0] n2;
        logic [DEN_W-1:0] d1;
        logic [DEN_W-1:0] d2;
        logic [DEN_W-1:0] rem1;
        logic [DEN_W-1:0] rem2;
        logic [NUM_W-1:0] q1;
        logic [NUM_W-1:0] q2;
        logic             neg1;
        logic             neg2;
        logic [COEF_W-1:0] x;
        logic             degen;
        logic             noroot;
    } t_dv;

endpackage

// File: sv/conic_column_root_solver_unit.sv
// Top level of the conic column root solver: registers, cell chains, output stage.
//
//  channel  | handshake           | payload
//  ---------+---------------------+-----------------------------------------------
//  input    | i_start / o_busy    | i_x_sample
//  result   | o_done (strobe)     | o_x_echo o_y_plus o_y_minus o_has_roots
//           |                     | o_degenerate o_saturated
//  config   | i_cfg_we            | i_cfg_idx i_cfg_data
//
// One item per cycle while o_busy is low; each item passes 6 front stages,
// 32 square root cells, one setup stage, 42 divider cells and the output
// register. o_busy is high only during reset and the cycle after;
// configuration registers reset to zero. Results are never held.
module conic_column_root_solver_unit import ccrs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [COEF_W-1:0] i_x_sample,
    output logic                     o_done,
    output logic signed [COEF_W-1:0] o_x_echo,
    output logic signed [Y_W-1:0]    o_y_plus,
    output logic signed [Y_W-1:0]    o_y_minus,
    output logic                     o_has_roots,
    output logic                     o_degenerate,
    output logic                     o_saturated,
    input  logic                     i_cfg_we,
    input  logic [IDX_W-1:0]         i_cfg_idx,
    input  logic [COEF_W-1:0]        i_cfg_data
);

    localparam int LATENCY = 82;
    localparam logic signed [NUM_W+2:0] Y_MAX = (NUM_W+3)'(2147483647);
    localparam logic signed [NUM_W+2:0] Y_MIN = -(NUM_W+3)'(64'sd2147483648);

    t_coefs r_coef;
    logic   r_live;

    logic   w_sq_vld [0:SQ_CELLS];
    t_sq    w_sq     [0:SQ_CELLS];
    logic   w_dv_vld [0:DV_CELLS];
    t_dv    w_dv     [0:DV_CELLS];
    logic   r_dv_vld;
    t_dv    r_dv;

    logic signed [B_W+1:0]    w_sb;
    logic signed [NUM_W-1:0]  w_n1, w_n2;
    logic [DEN_W-1:0]         w_cmag;
    logic signed [NUM_W+1:0]  w_y1;
    logic signed [NUM_W+1:0]  w_q2s;
    logic signed [NUM_W+2:0]  w_y1e, w_y2;
    logic                     w_clip1, w_clip2;
    t_dv                      w_fin;
    logic [ROOT_W-1:0]        w_s;

    assign o_busy = !r_live;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef <= '0;
            r_live <= 1'b0;
        end else begin
            r_live <= 1'b1;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    REG_XX:    r_coef.xx  <= i_cfg_data;
                    REG_XY:    r_coef.xy  <= i_cfg_data;
                    REG_YY:    r_coef.yy  <= i_cfg_data;
                    REG_X:     r_coef.x   <= i_cfg_data;
                    REG_Y:     r_coef.y   <= i_cfg_data;
                    REG_CONST: r_coef.cst <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    ccrs_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (i_start && r_live),
        .i_x     (i_x_sample),
        .i_coefs (r_coef),
        .o_vld   (w_sq_vld[0]),
        .o_dat   (w_sq[0])
    );

    for (genvar k = 0; k < SQ_CELLS; k++) begin : g_sqrt
        ccrs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_sq_vld[k]),
            .i_dat   (w_sq[k]),
            .o_vld   (w_sq_vld[k+1]),
            .o_dat   (w_sq[k+1])
        );
    end

    // divider setup: signed numerators to magnitudes, quotient signs
    assign w_s    = w_sq[SQ_CELLS].root;
    assign w_sb   = $signed({2'b00, w_s}) - (B_W+2)'(w_sq[SQ_CELLS].b);
    assign w_n1   = NUM_W'(w_sb) <<< Y_SHIFT;
    assign w_n2   = NUM_W'(w_sq[SQ_CELLS].b) <<< Y_SHIFT;
    assign w_cmag = r_coef.yy[COEF_W-1] ? DEN_W'(-(DEN_W'(r_coef.yy))) : DEN_W'(r_coef.yy);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv_vld <= 1'b0;
        end else begin
            r_dv_vld <= w_sq_vld[SQ_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_dv.n1     <= w_n1[NUM_W-1] ? NUM_W'(-w_n1) : NUM_W'(w_n1);
        r_dv.n2     <= w_n2[NUM_W-1] ? NUM_W'(-w_n2) : NUM_W'(w_n2);
        r_dv.d1     <= {w_cmag[DEN_W-2:0], 1'b0};
        r_dv.d2     <= w_cmag;
        r_dv.rem1   <= '0;
        r_dv.rem2   <= '0;
        r_dv.q1     <= '0;
        r_dv.q2     <= '0;
        r_dv.neg1   <= w_sb[B_W+1] ^ r_coef.yy[COEF_W-1];
        r_dv.neg2   <= w_sq[SQ_CELLS].b[B_W-1] ^ r_coef.yy[COEF_W-1];
        r_dv.x      <= w_sq[SQ_CELLS].x;
        r_dv.degen  <= w_sq[SQ_CELLS].degen;
        r_dv.noroot <= w_sq[SQ_CELLS].noroot;
    end

    assign w_dv_vld[0] = r_dv_vld;
    assign w_dv[0]     = r_dv;

    for (genvar k = 0; k < DV_CELLS; k++) begin : g_div
        ccrs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_vld   (w_dv_vld[k]),
            .i_dat   (w_dv[k]),
            .o_vld   (w_dv_vld[k+1]),
            .o_dat   (w_dv[k+1])
        );
    end

    // signed quotients, second root, saturation
    assign w_fin   = w_dv[DV_CELLS];
    assign w_y1    = w_fin.neg1 ? -$signed((NUM_W+2)'(w_fin.q1)) : $signed((NUM_W+2)'(w_fin.q1));
    assign w_q2s   = w_fin.neg2 ? -$signed((NUM_W+2)'(w_fin.q2)) : $signed((NUM_W+2)'(w_fin.q2));
    assign w_y1e   = (NUM_W+3)'(w_y1);
    assign w_y2    = -w_y1e - (NUM_W+3)'(w_q2s);
    assign w_clip1 = (w_y1e > Y_MAX) || (w_y1e < Y_MIN);
    assign w_clip2 = (w_y2 > Y_MAX) || (w_y2 < Y_MIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_done <= 1'b0;
        end else begin
            o_done <= w_dv_vld[DV_CELLS];
        end
    end

    always_ff @(posedge i_clk) begin
        o_x_echo     <= w_fin.x;
        o_degenerate <= w_fin.degen;
        if (w_fin.degen || w_fin.noroot) begin
            o_y_plus    <= '0;
            o_y_minus   <= '0;
            o_has_roots <= 1'b0;
            o_saturated <= 1'b0;
        end else begin
            o_y_plus    <= (w_y1e > Y_MAX) ? Y_W'(Y_MAX) :
                           (w_y1e < Y_MIN) ? Y_W'(Y_MIN) : Y_W'(w_y1e);
            o_y_minus   <= (w_y2 > Y_MAX) ? Y_W'(Y_MAX) :
                           (w_y2 < Y_MIN) ? Y_W'(Y_MIN) : Y_W'(w_y2);
            o_has_roots <= 1'b1;
            o_saturated <= w_clip1 || w_clip2;
        end
    end

`ifndef SYNTH
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |-> ##LATENCY o_done)
        else $error("item accepted without a result at the expected cycle");

    a_no_orphan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(i_start && !o_busy, LATENCY))
        else $error("result without a matching accepted item");

    a_degen_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_degenerate) |-> (!o_has_roots && !o_saturated &&
                                      o_y_plus == '0 && o_y_minus == '0))
        else $error("degenerate result carries roots");

    a_sat_roots: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_saturated) |-> o_has_roots)
        else $error("saturation flagged without roots");
`endif

endmodule

// File: sv/ccrs_front.sv
// Front pipeline: forms b, c and the discriminant over six stages.
module ccrs_front import ccrs_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_vld,
    input  logic signed [COEF_W-1:0] i_x,
    input  t_coefs                   i_coefs,
    output logic                     o_vld,
    output t_sq                      o_dat
);

    logic [5:0] r_vld;

    logic signed [COEF_W-1:0] r1_x;
    logic                     r1_degen;

    logic signed [PROD_W-1:0] r2_bx, r2_ax, r2_dx;
    logic signed [COEF_W-1:0] r2_x;
    logic                     r2_degen;

    logic signed [B_W-1:0]    r3_b;
    logic signed [C_W-1:0]    r3_axx;
    logic signed [PROD_W-1:0] r3_dx;
    logic [COEF_W-1:0]        r3_x;
    logic                     r3_degen;

    logic signed [C_W-1:0]    r4_c;
    logic signed [B_W-1:0]    r4_b;
    logic [COEF_W-1:0]        r4_x;
    logic                     r4_degen;

    logic [DISC_W-1:0]        r5_p, r5_m;
    logic                     r5_same;
    logic signed [B_W-1:0]    r5_b;
    logic [COEF_W-1:0]        r5_x;
    logic                     r5_degen;

    logic [B_W-1:0]           w_bm;
    logic [C_W-1:0]           w_cm;
    logic [COEF_W-1:0]        w_ym;
    logic [DISC_W-1:0]        w_m4;

    assign w_bm = r4_b[B_W-1] ? B_W'(-r4_b) : B_W'(r4_b);
    assign w_cm = r4_c[C_W-1] ? C_W'(-r4_c) : C_W'(r4_c);
    assign w_ym = i_coefs.yy[COEF_W-1] ? COEF_W'(-(DEN_W'(i_coefs.yy)))
                                       : COEF_W'(i_coefs.yy);
    assign w_m4 = {r5_m[DISC_W-3:0], 2'b00};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_vld};
        end
    end

    always_ff @(posedge i_clk) begin
        r1_x     <= i_x;
        r1_degen <= (i_coefs.yy == '0);

        r2_bx    <= PROD_W'(i_coefs.xy) * PROD_W'(r1_x);
        r2_ax    <= PROD_W'(i_coefs.xx) * PROD_W'(r1_x);
        r2_dx    <= PROD_W'(i_coefs.x) * PROD_W'(r1_x);
        r2_x     <= r1_x;
        r2_degen <= r1_degen;

        r3_b     <= r2_bx + (B_W'(i_coefs.y) <<< FRAC);
        r3_axx   <= C_W'(r2_ax) * C_W'(r2_x);
        r3_dx    <= r2_dx;
        r3_x     <= r2_x;
        r3_degen <= r2_degen;

        r4_c     <= r3_axx + (C_W'(r3_dx) <<< FRAC) + (C_W'(i_coefs.cst) <<< (2 * FRAC));
        r4_b     <= r3_b;
        r4_x     <= r3_x;
        r4_degen <= r3_degen;

        r5_p     <= DISC_W'(w_bm) * DISC_W'(w_bm);
        r5_m     <= DISC_W'(w_ym) * DISC_W'(w_cm);
        r5_same  <= (i_coefs.yy[COEF_W-1] == r4_c[C_W-1]);
        r5_b     <= r4_b;
        r5_x     <= r4_x;
        r5_degen <= r4_degen;

        o_dat.v      <= r5_same ? (r5_p - w_m4) : (r5_p + w_m4);
        o_dat.noroot <= r5_same && (r5_p < w_m4);
        o_dat.rem    <= '0;
        o_dat.root   <= '0;
        o_dat.b      <= r5_b;
        o_dat.x      <= r5_x;
        o_dat.degen  <= r5_degen;
    end

    assign o_vld = r_vld[5];

endmodule

// File: sv/ccrs_sqrt_cell.sv
// One digit cell of the pipelined integer square root.
module ccrs_sqrt_cell import ccrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_sq  i_dat,
    output logic o_vld,
    output t_sq  o_dat
);

    logic [REM_W-1:0] w_rem;
    logic [REM_W-1:0] w_trial;
    logic             w_ge;

    assign w_rem   = {i_dat.rem[REM_W-3:0], i_dat.v[DISC_W-1 -: 2]};
    assign w_trial = REM_W'({i_dat.root, 2'b01});
    assign w_ge    = (w_rem >= w_trial);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_dat.v      <= {i_dat.v[DISC_W-3:0], 2'b00};
        o_dat.rem    <= w_ge ? (w_rem - w_trial) : w_rem;
        o_dat.root   <= {i_dat.root[ROOT_W-2:0], w_ge};
        o_dat.b      <= i_dat.b;
        o_dat.x      <= i_dat.x;
        o_dat.degen  <= i_dat.degen;
        o_dat.noroot <= i_dat.noroot;
    end

endmodule

// File: sv/ccrs_div_cell.sv
// One quotient-bit cell of the two pipelined restoring dividers.
module ccrs_div_cell import ccrs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_vld,
    input  t_dv  i_dat,
    output logic o_vld,
    output t_dv  o_dat
);

    logic [DEN_W:0] w_r1, w_r2, w_s1, w_s2;
    logic           w_ge1, w_ge2;

    assign w_r1  = {i_dat.rem1, i_dat.n1[NUM_W-1]};
    assign w_r2  = {i_dat.rem2, i_dat.n2[NUM_W-1]};
    assign w_ge1 = (w_r1 >= {1'b0, i_dat.d1});
    assign w_ge2 = (w_r2 >= {1'b0, i_dat.d2});
    assign w_s1  = w_r1 - {1'b0, i_dat.d1};
    assign w_s2  = w_r2 - {1'b0, i_dat.d2};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_vld <= 1'b0;
        end else begin
            o_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        o_dat.n1     <= {i_dat.n1[NUM_W-2:0], 1'b0};
        o_dat.n2     <= {i_dat.n2[NUM_W-2:0], 1'b0};
        o_dat.d1     <= i_dat.d1;
        o_dat.d2     <= i_dat.d2;
        o_dat.rem1   <= w_ge1 ? w_s1[DEN_W-1:0] : w_r1[DEN_W-1:0];
        o_dat.rem2   <= w_ge2 ? w_s2[DEN_W-1:0] : w_r2[DEN_W-1:0];
        o_dat.q1     <= {i_dat.q1[NUM_W-2:0], w_ge1};
        o_dat.q2     <= {i_dat.q2[NUM_W-2:0], w_ge2};
        o_dat.neg1   <= i_dat.neg1;
        o_dat.neg2   <= i_dat.neg2;
        o_dat.x      <= i_dat.x;
        o_dat.degen  <= i_dat.degen;
        o_dat.noroot <= i_dat.noroot;
    end

endmodule
